### rtl/core/grs_pkg.sv
// Shared types, constants and the logistic table of the graded response sampler.
package grs_pkg;

    // Number of register stages from input acceptance to the output register.
    localparam int NSTAGE = 5;

    // Number of difficulty inputs on the item interface.
    localparam int DIFF_INPUTS = 4;

    // The probability 1.0 in 16-bit fraction units.
    localparam logic [16:0] Q_ONE = 17'd65536;

    // Logistic samples round(65536 / (1 + exp(-t))) for t = 0, 0.5, ..., 8.
    localparam logic [15:0] LOGISTIC_TAB [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    // Signed Q4.12 value.
    typedef logic signed [15:0] t_q412;

    // Probability in 16-bit fraction units, with room for 1.0.
    typedef logic [16:0] t_prob;

    // Stage controls and shared side-band values handed to the lanes.
    typedef struct packed {
        logic [NSTAGE-1:0] load;      // stage k register takes new data
        logic              out_valid; // output register holds an item
        logic [15:0]       slope;     // slope aligned with stage 0
        logic [15:0]       draw;      // uniform draw aligned with stage 3
        logic [2:0]        used;      // categories in use, aligned with stage 3
    } t_pipe_ctl;

endpackage

### rtl/core/graded_response_sampler.sv
// One lane per category; an accepted item passes the stage 0 to stage 4 registers to reach the output.
// Throughput: one item per cycle unless the output stalls, set by the five-stage pipeline.
// The per-category slope multiply sits alone in stage 1; the table lookup in stage 3.
// Reset (synchronous, active low) empties the pipeline and sets category_count to 4.
// Top level of the graded response sampler.
module graded_response_sampler
    import grs_pkg::*;
#(
    parameter int MAX_CATEGORIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_q412       i_ability,
    input  logic [15:0] i_slope,
    input  t_q412       i_difficulty_0,
    input  t_q412       i_difficulty_1,
    input  t_q412       i_difficulty_2,
    input  t_q412       i_difficulty_3,
    input  logic [15:0] i_uniform_draw,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_response_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    localparam int LANES = (MAX_CATEGORIES < DIFF_INPUTS) ? MAX_CATEGORIES : DIFF_INPUTS;
    localparam logic [2:0] LANES_W = 3'(LANES);

    logic [2:0] r_category_count;
    logic [2:0] w_used;
    logic [2:0] r_level;
    logic [2:0] n_level;
    t_pipe_ctl  w_ctl;
    t_q412      w_diff [0:DIFF_INPUTS-1];
    t_prob      w_prob [0:LANES-1];

    // Category count register; writes are always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_category_count <= 3'd4;
        end else if (i_cfg_valid) begin
            r_category_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_used      = (r_category_count > LANES_W) ? LANES_W : r_category_count;

    assign w_diff[0] = i_difficulty_0;
    assign w_diff[1] = i_difficulty_1;
    assign w_diff[2] = i_difficulty_2;
    assign w_diff[3] = i_difficulty_3;

    grs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_out_stall    (i_out_stall),
        .i_slope        (i_slope),
        .i_uniform_draw (i_uniform_draw),
        .i_used         (w_used),
        .o_ctl          (w_ctl)
    );

    // One lane per category.
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        grs_lane u_lane (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_ability    (i_ability),
            .i_difficulty (w_diff[k]),
            .o_prob       (w_prob[k])
        );
    end

    // Stage 4: count the categories in use whose probability beats the draw.
    always_comb begin
        n_level = '0;
        for (int k = 0; k < LANES; k++) begin
            if ((3'(k) < w_ctl.used) && (w_prob[k] > {1'b0, w_ctl.draw})) begin
                n_level = n_level + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[NSTAGE-1]) begin
            r_level <= n_level;
        end
    end

    assign o_out_valid      = w_ctl.out_valid;
    assign o_response_level = r_level;

    // A result never counts more categories than there are lanes.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_response_level <= LANES_W))
        else $error("response level above the lane count");

    // A configuration write lands in the register on the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_category_count == $past(i_cfg_data)))
        else $error("category count write not taken");

    // Reset restores the default category count.
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_category_count == 3'd4))
        else $error("category count not reset to four");

endmodule

### rtl/core/grs_ctrl.sv
// Pipeline valid bits, stall propagation and shared side-band registers.
module grs_ctrl
    import grs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_out_stall,
    input  logic [15:0] i_slope,
    input  logic [15:0] i_uniform_draw,
    input  logic [2:0]  i_used,
    output t_pipe_ctl   o_ctl
);

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] w_rdy;
    logic [NSTAGE-1:0] w_load;
    logic [15:0]       r_slope;
    logic [15:0]       r_draw [0:NSTAGE-2];
    logic [2:0]        r_used [0:NSTAGE-2];

    // A stage can take data when it is empty or its content moves on.
    always_comb begin
        w_rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_load[0] = i_in_valid && w_rdy[0];
        for (int k = 1; k < NSTAGE; k++) begin
            w_load[k] = r_vld[k-1] && w_rdy[k];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Slope is registered with its item at stage 0; draw and category count follow their item down the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_slope   <= i_slope;
            r_draw[0] <= i_uniform_draw;
            r_used[0] <= i_used;
        end
        for (int k = 1; k < NSTAGE - 1; k++) begin
            if (w_load[k]) begin
                r_draw[k] <= r_draw[k-1];
                r_used[k] <= r_used[k-1];
            end
        end
    end

    assign o_in_stall      = !w_rdy[0];
    assign o_ctl.load      = w_load;
    assign o_ctl.out_valid = r_vld[NSTAGE-1];
    assign o_ctl.slope     = r_slope;
    assign o_ctl.draw      = r_draw[NSTAGE-2];
    assign o_ctl.used      = r_used[NSTAGE-2];

    // The input is held off only when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld == {NSTAGE{1'b1}}))
        else $error("input stalled while a stage is empty");

    // An occupied stage that cannot move keeps its item.
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-1] && i_out_stall) |=> r_vld[NSTAGE-1])
        else $error("output item lost under stall");

    // The output stage is loaded only when its predecessor holds an item.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load[NSTAGE-1] |-> r_vld[NSTAGE-2])
        else $error("output stage loaded from an empty stage");

endmodule

### rtl/core/grs_lane.sv
// Datapath of one category: difference, scaling, saturation and logistic lookup.
module grs_lane
    import grs_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_q412     i_ability,
    input  t_q412     i_difficulty,
    output t_prob     o_prob
);

    t_q412              r_d;
    logic signed [31:0] r_prod;
    logic [15:0]        r_a;
    logic               r_neg;
    t_prob              r_p;

    logic signed [16:0] w_diff;
    t_q412              n_d;
    logic signed [31:0] n_prod;
    logic signed [19:0] w_shift;
    t_q412              w_x;
    logic signed [16:0] w_abs;
    logic [3:0]         w_idx;
    logic [15:0]        w_lo;
    logic [15:0]        w_step;
    logic [26:0]        w_interp;
    logic [16:0]        w_mag;
    t_prob              n_p;

    // Stage 0: saturated difference of ability and threshold.
    always_comb begin
        w_diff = 17'(i_ability) - 17'(i_difficulty);
        if (w_diff > 17'sd32767) begin
            n_d = 16'sh7fff;
        end else if (w_diff < -17'sd32768) begin
            n_d = 16'sh8000;
        end else begin
            n_d = w_diff[15:0];
        end
    end

    // Stage 1: unsigned slope times signed difference, exact in 32 bits.
    assign n_prod = 32'($signed({1'b0, i_ctl.slope}) * r_d);

    // Stage 2: floor shift back to Q4.12, saturation, then magnitude and sign.
    always_comb begin
        w_shift = r_prod[31:12];
        if (w_shift > 20'sd32767) begin
            w_x = 16'sh7fff;
        end else if (w_shift < -20'sd32768) begin
            w_x = 16'sh8000;
        end else begin
            w_x = w_shift[15:0];
        end
        w_abs = w_x[15] ? (17'sd0 - 17'(w_x)) : 17'(w_x);
    end

    // Stage 3: linear interpolation between table samples, mirrored for negative x.
    always_comb begin
        w_idx    = r_a[14:11];
        w_lo     = LOGISTIC_TAB[w_idx];
        w_step   = LOGISTIC_TAB[5'(w_idx) + 5'd1] - w_lo;
        w_interp = 27'(w_step) * 27'(r_a[10:0]) + 27'd1024;
        if (r_a[15]) begin
            w_mag = 17'(LOGISTIC_TAB[16]);
        end else begin
            w_mag = 17'(w_lo) + 17'(w_interp[26:11]);
        end
        n_p = r_neg ? (Q_ONE - w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_d <= n_d;
        end
        if (i_ctl.load[1]) begin
            r_prod <= n_prod;
        end
        if (i_ctl.load[2]) begin
            r_a   <= w_abs[15:0];
            r_neg <= w_x[15];
        end
        if (i_ctl.load[3]) begin
            r_p <= n_p;
        end
    end

    assign o_prob = r_p;

endmodule

### bench/tb_graded_response_sampler.sv
// Self-checking testbench for the graded response sampler: random and directed items against a predictor.
`timescale 1ns / 100ps

module tb_graded_response_sampler;
    import grs_pkg::*;

    localparam int MAX_CATEGORIES = 4;
    // Cycles to let pass after the last result before touching the register or ending.
    localparam int SETTLE_CYCLES = NSTAGE + 3;
    localparam int RANDOM_PER_PHASE = 200;

    // Logistic samples of 1/(1+exp(-t)) in 16-bit fraction units, t = 0, 0.5, ..., 8.
    localparam int unsigned LOGIT_TAB [0:16] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    // One test item as presented on the input side.
    typedef struct packed {
        logic [15:0]      ability;
        logic [15:0]      slope;
        logic [3:0][15:0] difficulty;
        logic [15:0]      draw;
    } t_trial;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_q412       i_ability = '0;
    logic [15:0] i_slope = '0;
    t_q412       i_difficulty_0 = '0;
    t_q412       i_difficulty_1 = '0;
    t_q412       i_difficulty_2 = '0;
    t_q412       i_difficulty_3 = '0;
    logic [15:0] i_uniform_draw = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_response_level;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;

    t_trial      trials_pending[$];
    logic [2:0]  response_due[$];
    t_trial      active_trial;
    logic [2:0]  category_count_cfg = 3'd4;
    int unsigned in_gap_max = 0;
    int unsigned out_gap_max = 0;
    int unsigned in_wait = 0;
    int unsigned out_hold = 0;
    int          mismatches = 0;
    int          responses_checked = 0;
    int          level_seen [0:7];
    int          settings_run = 0;

    graded_response_sampler #(
        .MAX_CATEGORIES(MAX_CATEGORIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_ability       (i_ability),
        .i_slope         (i_slope),
        .i_difficulty_0  (i_difficulty_0),
        .i_difficulty_1  (i_difficulty_1),
        .i_difficulty_2  (i_difficulty_2),
        .i_difficulty_3  (i_difficulty_3),
        .i_uniform_draw  (i_uniform_draw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_response_level(o_response_level),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected response level: per category, saturate the difference, scale by the slope,
    // floor back to Q4.12, saturate, look up the logistic and compare with the draw.
    function automatic logic [2:0] predict_response_level(input t_trial tr,
                                                          input logic [2:0] count);
        longint diff;
        longint prod;
        longint x;
        longint mag;
        longint seg;
        longint frac;
        longint prob;
        int     used;
        int     level;
        used = (int'(count) > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(count);
        if (used > DIFF_INPUTS) begin
            used = DIFF_INPUTS;
        end
        level = 0;
        for (int k = 0; k < used; k++) begin
            diff = longint'($signed(tr.ability)) - longint'($signed(tr.difficulty[k]));
            if (diff > 32767) begin
                diff = 32767;
            end else if (diff < -32768) begin
                diff = -32768;
            end
            prod = longint'(tr.slope) * diff;
            x = prod >>> 12;
            if (x > 32767) begin
                x = 32767;
            end else if (x < -32768) begin
                x = -32768;
            end
            mag = (x < 0) ? -x : x;
            seg = mag >> 11;
            frac = mag & 2047;
            if (seg >= 16) begin
                prob = LOGIT_TAB[16];
            end else begin
                prob = LOGIT_TAB[seg] +
                       (((LOGIT_TAB[seg + 1] - LOGIT_TAB[seg]) * frac + 1024) >> 11);
            end
            // Negative arguments mirror the curve around one half.
            if (x < 0) begin
                prob = 65536 - prob;
            end
            if (prob > longint'(tr.draw)) begin
                level++;
            end
        end
        return 3'(level);
    endfunction

    // Realistic items dominate: moderate ability, ascending thresholds, typical slopes.
    // The rest spans every bit of every field.
    function automatic t_trial random_trial();
        t_trial tr;
        int     d;
        if ($urandom_range(0, 9) < 6) begin
            tr.ability = 16'(int'($urandom_range(0, 32768)) - 16384);
            tr.slope = 16'($urandom_range(1024, 16384));
            d = int'($urandom_range(0, 20480)) - 16384;
            for (int k = 0; k < 4; k++) begin
                tr.difficulty[k] = 16'(d);
                d = d + int'($urandom_range(0, 8192));
                if (d > 32767) begin
                    d = 32767;
                end
            end
        end else begin
            tr.ability = 16'($urandom);
            tr.slope = 16'($urandom);
            for (int k = 0; k < 4; k++) begin
                tr.difficulty[k] = 16'($urandom);
            end
        end
        tr.draw = 16'($urandom);
        return tr;
    endfunction

    task automatic queue_trial(input int ab, input int sl, input int d0, input int d1,
                               input int d2, input int d3, input int dr);
        t_trial tr;
        tr.ability = 16'(ab);
        tr.slope = 16'(sl);
        tr.difficulty[0] = 16'(d0);
        tr.difficulty[1] = 16'(d1);
        tr.difficulty[2] = 16'(d2);
        tr.difficulty[3] = 16'(d3);
        tr.draw = 16'(dr);
        trials_pending.push_back(tr);
    endtask

    task automatic present_trial(input t_trial tr);
        i_ability <= tr.ability;
        i_slope <= tr.slope;
        i_difficulty_0 <= tr.difficulty[0];
        i_difficulty_1 <= tr.difficulty[1];
        i_difficulty_2 <= tr.difficulty[2];
        i_difficulty_3 <= tr.difficulty[3];
        i_uniform_draw <= tr.draw;
    endtask

    // Wait until every queued item went in and every response came back.
    task automatic settle();
        while (trials_pending.size() != 0 || i_in_valid || response_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_category_count(input logic [2:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        category_count_cfg = value;
    endtask

    // Input driver: presents queued items, predicts each one as it is accepted,
    // and waits a random number of cycles after each item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait = 0;
        end else if (i_in_valid && !o_in_stall) begin
            response_due.push_back(predict_response_level(active_trial, category_count_cfg));
            in_wait = $urandom_range(0, in_gap_max);
            if (in_wait == 0 && trials_pending.size() != 0) begin
                active_trial = trials_pending.pop_front();
                present_trial(active_trial);
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (in_wait != 0) begin
                in_wait--;
            end
            if (in_wait == 0 && trials_pending.size() != 0) begin
                active_trial = trials_pending.pop_front();
                present_trial(active_trial);
                i_in_valid <= 1'b1;
            end
        end
    end

    // Output monitor: checks each accepted response against the oldest prediction,
    // then stalls the output for a random number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (response_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected response level %0d with nothing outstanding",
                                 o_response_level);
                    end
                end else begin
                    logic [2:0] want;
                    want = response_due.pop_front();
                    if (o_response_level !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Response %0d: expected level %0d, got %0d (count %0d)",
                                     responses_checked, want, o_response_level,
                                     category_count_cfg);
                        end
                    end
                    responses_checked++;
                    level_seen[want]++;
                end
                out_hold = $urandom_range(0, out_gap_max);
            end else if (out_hold != 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    // Stimulus: directed items at the reset setting, then random phases over the settings.
    initial begin
        logic [2:0] settings [0:8];
        settings = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
        for (int v = 0; v < 8; v++) begin
            level_seen[v] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero arguments sit exactly on one half.
        queue_trial(0, 0, 0, 0, 0, 0, 0);
        queue_trial(0, 0, 0, 0, 0, 0, 32767);
        queue_trial(0, 0, 0, 0, 0, 0, 32768);
        queue_trial(0, 0, 0, 0, 0, 0, 65535);
        // Saturated positive argument: the top of the table, strictly greater matters.
        queue_trial(32767, 65535, -32768, -32768, -32768, -32768, 65513);
        queue_trial(32767, 65535, -32768, -32768, -32768, -32768, 65514);
        queue_trial(32767, 65535, -32768, -32768, -32768, -32768, 65535);
        // Saturated negative argument reaches the end of the table.
        queue_trial(-32768, 65535, 32767, 32767, 32767, 32767, 21);
        queue_trial(-32768, 65535, 32767, 32767, 32767, 32767, 22);
        // Zero slope flattens any difference.
        queue_trial(32767, 0, -32768, 32767, 0, -1, 32767);
        // Ascending thresholds give intermediate levels.
        queue_trial(0, 4096, -8192, -2048, 2048, 8192, 32768);
        queue_trial(0, 4096, -8192, -2048, 2048, 8192, 50000);
        queue_trial(0, 4096, -8192, -2048, 2048, 8192, 10000);
        // Segment boundaries and the smallest products, floor rounding of negatives.
        queue_trial(2048, 4096, 0, -2048, 4096, 30720, 40793);
        queue_trial(1, 1, 0, 0, 0, 0, 32767);
        queue_trial(-1, 1, 0, 0, 0, 0, 32764);
        queue_trial(-1, 1, 0, 0, 0, 0, 32763);
        // Saturated difference with unit slope, and a huge slope on a small difference.
        queue_trial(32767, 1, -32768, -1, 0, 1, 32770);
        queue_trial(4096, 65535, 0, 8192, 4095, 4097, 65500);
        settle();

        foreach (settings[p]) begin
            if (p != 0) begin
                set_category_count(settings[p]);
            end
            in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            repeat (RANDOM_PER_PHASE) trials_pending.push_back(random_trial());
            settle();
            settings_run++;
        end

        $display("Checked %0d responses over %0d category-count settings, zero and oversize included.",
                 responses_checked, settings_run);
        $display("Response levels 0..4 seen: %0d %0d %0d %0d %0d",
                 level_seen[0], level_seen[1], level_seen[2], level_seen[3], level_seen[4]);
        if (mismatches == 0 && response_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches, response_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("Timed out with %0d responses outstanding", response_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
